>>> rtl/hmc_pkg.sv
// Shared types and constants of the merge-cost unit.
// Used by hmc_ctrl, hmc_datapath and huffman_merge_cost_unit; no dependencies.
package hmc_pkg;

  localparam int IN_LEN_W  = 16;  // piece_length port width
  localparam int LEAF_W    = 16;  // leaf_length port width
  localparam int COST_W    = 28;  // total_cost port width
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  // Controller to datapath commands
  typedef struct packed {
    logic load_wr;      // write incoming piece into the store
    logic sort_first;   // bubble pass: take first element as carried value
    logic sort_step;    // bubble pass: write min, carry max
    logic sort_end;     // bubble pass: write carried value at pass end
    logic cost_clear;   // clear cost accumulator
    logic pick;         // take smallest weight
    logic pick_second;  // this pick completes a merge
    logic leaf_ok;      // leaf head is valid
    logic q_ok;         // merged queue head is valid
    logic out_load;     // load output register
    logic out_last;     // flag of the result being loaded
  } hmc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic take_leaf;    // current pick comes from the leaves
  } hmc_stat_t;

endpackage

>>> rtl/hmc_datapath.sv
// Datapath of the merge-cost unit: piece store, merged-sum queue, cost and output registers.
// Depends on hmc_pkg; driven by hmc_ctrl.
module hmc_datapath #(
  parameter int MAX_PIECES  = 64,
  parameter int LENGTH_BITS = 16,
  parameter int IDX_W       = 6
) (
  input  logic                           clk,
  input  hmc_pkg::hmc_cmd_t              cmd,
  output hmc_pkg::hmc_stat_t             stat,
  input  logic [IDX_W-1:0]               st_raddr,
  input  logic [IDX_W-1:0]               st_waddr,
  input  logic [IDX_W-1:0]               q_raddr,
  input  logic [IDX_W-1:0]               q_waddr,
  input  logic [hmc_pkg::IN_LEN_W-1:0]   piece_length,
  output logic [hmc_pkg::COST_W-1:0]     total_cost,
  output logic [hmc_pkg::LEAF_W-1:0]     leaf_length,
  output logic                           last_result
);
  import hmc_pkg::*;

  // merged sums never exceed the sum of all leaves
  localparam int SW = LENGTH_BITS + $clog2(MAX_PIECES);
  localparam int AW = ((SW > COST_W) ? SW : COST_W) + 1;

  logic [LENGTH_BITS-1:0] store [MAX_PIECES];
  logic [SW-1:0]          queue [MAX_PIECES];

  logic [LENGTH_BITS-1:0] st_rdata;
  logic [SW-1:0]          q_rdata;
  logic [LENGTH_BITS-1:0] cur;
  logic [SW-1:0]          opa;
  logic [COST_W-1:0]      cost;

  logic [IN_LEN_W+LENGTH_BITS-1:0] in_wide;
  logic [LENGTH_BITS+LEAF_W-1:0]   leaf_wide;
  logic [LENGTH_BITS-1:0]          in_len;
  logic                            swap;
  logic [LENGTH_BITS-1:0]          st_wdata;
  logic                            st_we;
  logic [SW-1:0]                   leaf_ext;
  logic [SW-1:0]                   pick_val;
  logic [SW-1:0]                   sum;
  logic [AW-1:0]                   cost_sum;

  assign in_wide   = {{LENGTH_BITS{1'b0}}, piece_length};
  assign in_len    = in_wide[LENGTH_BITS-1:0];
  assign leaf_wide = {{LEAF_W{1'b0}}, st_rdata};

  assign swap     = cur > st_rdata;
  assign st_we    = cmd.load_wr | cmd.sort_step | cmd.sort_end;
  always_comb begin
    if (cmd.load_wr) begin
      st_wdata = in_len;
    end else if (cmd.sort_step) begin
      st_wdata = swap ? st_rdata : cur;
    end else begin
      st_wdata = cur;
    end
  end

  // merged sum wins ties
  assign leaf_ext       = SW'(st_rdata);
  assign stat.take_leaf = cmd.leaf_ok & (~cmd.q_ok | (leaf_ext < q_rdata));
  always_comb begin
    if (stat.take_leaf) begin
      pick_val = leaf_ext;
    end else if (cmd.q_ok) begin
      pick_val = q_rdata;
    end else begin
      pick_val = '0;
    end
  end
  assign sum      = opa + pick_val;
  assign cost_sum = AW'(cost) + AW'(sum);

  always_ff @(posedge clk) begin
    if (st_we) begin
      store[st_waddr] <= st_wdata;
    end
    st_rdata <= store[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.pick && cmd.pick_second) begin
      queue[q_waddr] <= sum;
    end
    q_rdata <= queue[q_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.sort_first) begin
      cur <= st_rdata;
    end else if (cmd.sort_step && !swap) begin
      cur <= st_rdata;
    end
    if (cmd.pick && !cmd.pick_second) begin
      opa <= pick_val;
    end
    if (cmd.cost_clear) begin
      cost <= '0;
    end else if (cmd.pick && cmd.pick_second) begin
      cost <= (cost_sum > AW'(COST_MAX)) ? COST_MAX : cost_sum[COST_W-1:0];
    end
    if (cmd.out_load) begin
      total_cost  <= cost;
      leaf_length <= leaf_wide[LEAF_W-1:0];
      last_result <= cmd.out_last;
    end
  end

endmodule

>>> rtl/hmc_ctrl.sv
// Sequencer of the merge-cost unit: load, bubble sort, two-queue merge, emit.
// Depends on hmc_pkg; issues commands and addresses to hmc_datapath.
module hmc_ctrl #(
  parameter int MAX_PIECES = 64,
  parameter int IDX_W      = 6,
  parameter int CNT_W      = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               last_piece,
  output logic               out_valid,
  input  logic               out_stall,
  output hmc_pkg::hmc_cmd_t  cmd,
  input  hmc_pkg::hmc_stat_t stat,
  output logic [IDX_W-1:0]   st_raddr,
  output logic [IDX_W-1:0]   st_waddr,
  output logic [IDX_W-1:0]   q_raddr,
  output logic [IDX_W-1:0]   q_waddr
);
  import hmc_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD, S_PREP, S_SORT_START, S_SORT_FIRST, S_SORT_RUN, S_SORT_END,
    S_MRG_INIT, S_MRG_FETCH, S_MRG_PICK, S_EMIT_RD, S_EMIT_LD, S_EMIT_WAIT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] lim;
  logic [IDX_W-1:0] j;
  logic [IDX_W-1:0] e;
  logic [CNT_W-1:0] li;
  logic [CNT_W-1:0] qh;
  logic [CNT_W-1:0] qt;
  logic [CNT_W-1:0] m;
  logic             phase;
  logic             in_xfer;

  assign in_stall = (state != S_LOAD);
  assign in_xfer  = in_valid & ~in_stall;

  always_comb begin
    cmd             = '0;
    cmd.load_wr     = in_xfer && (count < CNT_W'(MAX_PIECES));
    cmd.cost_clear  = (state == S_PREP);
    cmd.sort_first  = (state == S_SORT_FIRST);
    cmd.sort_step   = (state == S_SORT_RUN);
    cmd.sort_end    = (state == S_SORT_END);
    cmd.pick        = (state == S_MRG_PICK);
    cmd.pick_second = phase;
    cmd.leaf_ok     = (li < count);
    cmd.q_ok        = (qh < qt);
    cmd.out_load    = (state == S_EMIT_LD);
    cmd.out_last    = (e == '0);

    case (state)
      S_SORT_START: st_raddr = '0;
      S_SORT_FIRST: st_raddr = j;
      S_SORT_RUN:   st_raddr = j + IDX_W'(1);
      S_MRG_FETCH:  st_raddr = li[IDX_W-1:0];
      default:      st_raddr = e;
    endcase

    case (state)
      S_SORT_RUN: st_waddr = j - IDX_W'(1);
      S_SORT_END: st_waddr = lim;
      default:    st_waddr = count[IDX_W-1:0];
    endcase

    q_raddr = qh[IDX_W-1:0];
    q_waddr = qt[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_xfer) begin
            if (count < CNT_W'(MAX_PIECES)) begin
              count <= count + CNT_W'(1);
            end
            if (last_piece) begin
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          if (count == CNT_W'(1)) begin
            e     <= '0;
            state <= S_EMIT_RD;
          end else begin
            lim   <= IDX_W'(count - CNT_W'(1));
            state <= S_SORT_START;
          end
        end
        S_SORT_START: begin
          j     <= IDX_W'(1);
          state <= S_SORT_FIRST;
        end
        S_SORT_FIRST: state <= S_SORT_RUN;
        S_SORT_RUN: begin
          if (j == lim) begin
            state <= S_SORT_END;
          end else begin
            j <= j + IDX_W'(1);
          end
        end
        S_SORT_END: begin
          if (lim == IDX_W'(1)) begin
            state <= S_MRG_INIT;
          end else begin
            lim   <= lim - IDX_W'(1);
            state <= S_SORT_START;
          end
        end
        S_MRG_INIT: begin
          li    <= '0;
          qh    <= '0;
          qt    <= '0;
          m     <= '0;
          phase <= 1'b0;
          state <= S_MRG_FETCH;
        end
        S_MRG_FETCH: state <= S_MRG_PICK;
        S_MRG_PICK: begin
          if (stat.take_leaf) begin
            li <= li + CNT_W'(1);
          end else begin
            qh <= qh + CNT_W'(1);
          end
          phase <= ~phase;
          if (!phase) begin
            state <= S_MRG_FETCH;
          end else begin
            qt <= qt + CNT_W'(1);
            if (m == count - CNT_W'(2)) begin
              e     <= IDX_W'(count - CNT_W'(1));
              state <= S_EMIT_RD;
            end else begin
              m     <= m + CNT_W'(1);
              state <= S_MRG_FETCH;
            end
          end
        end
        S_EMIT_RD: state <= S_EMIT_LD;
        S_EMIT_LD: begin
          out_valid <= 1'b1;
          state     <= S_EMIT_WAIT;
        end
        S_EMIT_WAIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (e == '0) begin
              count <= '0;
              state <= S_LOAD;
            end else begin
              e     <= e - IDX_W'(1);
              state <= S_EMIT_RD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_load_while_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_PIECES))
    else $error("piece count beyond store depth");

  a_merge_ptrs: assert property (@(posedge clk) disable iff (rst)
    (state == S_MRG_PICK) |-> ((qh <= qt) && (li <= count) && (cmd.leaf_ok || cmd.q_ok)))
    else $error("merge pointers out of order");

  a_run_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && (e == '0)) |=> (!out_valid && !in_stall && (count == '0)))
    else $error("set not closed after final result");
`endif

endmodule

>>> rtl/huffman_merge_cost_unit.sv
// Top level of the merge-cost unit.
// Depends on hmc_pkg, hmc_ctrl and hmc_datapath.
//
// Usage:
//   Input channel (in_valid/in_stall): one piece_length per transfer, one
//   transfer per cycle while loading. last_piece closes the set. Pieces past
//   MAX_PIECES are dropped; a last_piece on a dropped transfer still closes.
//   Output channel (out_valid/out_stall): one result per stored piece, leaf
//   lengths in descending order, total_cost equal in every result of the
//   set, last_result on the final one. One piece gives cost 0.
//   Steps for a set of n pieces after the closing transfer:
//     sort:  bubble passes over the store for lim = n-1 down to 1, one
//            memory read and write per cycle
//     merge: n-1 merges, each of two picks (each a registered read
//            of both memories and a compare)
//     emit:  per result, a registered read of the single store read port,
//            a load of the output register, then a wait until it is taken.
//   in_stall is high from the closing transfer until the final result has
//   been taken; a stalled receiver just holds the output register.
//   Reset (rst, synchronous): empty set, loading, out_valid low.
module huffman_merge_cost_unit #(
  parameter int MAX_PIECES  = 64,
  parameter int LENGTH_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [hmc_pkg::IN_LEN_W-1:0]   piece_length,
  input  logic                           last_piece,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [hmc_pkg::COST_W-1:0]     total_cost,
  output logic [hmc_pkg::LEAF_W-1:0]     leaf_length,
  output logic                           last_result
);
  import hmc_pkg::*;

  localparam int IDX_W = $clog2(MAX_PIECES);
  localparam int CNT_W = $clog2(MAX_PIECES + 1);

  hmc_cmd_t         cmd;
  hmc_stat_t        stat;
  logic [IDX_W-1:0] st_raddr;
  logic [IDX_W-1:0] st_waddr;
  logic [IDX_W-1:0] q_raddr;
  logic [IDX_W-1:0] q_waddr;

  hmc_ctrl #(
    .MAX_PIECES(MAX_PIECES),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .last_piece(last_piece),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat),
    .st_raddr  (st_raddr),
    .st_waddr  (st_waddr),
    .q_raddr   (q_raddr),
    .q_waddr   (q_waddr)
  );

  hmc_datapath #(
    .MAX_PIECES (MAX_PIECES),
    .LENGTH_BITS(LENGTH_BITS),
    .IDX_W      (IDX_W)
  ) u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .stat        (stat),
    .st_raddr    (st_raddr),
    .st_waddr    (st_waddr),
    .q_raddr     (q_raddr),
    .q_waddr     (q_waddr),
    .piece_length(piece_length),
    .total_cost  (total_cost),
    .leaf_length (leaf_length),
    .last_result (last_result)
  );

endmodule

>>> tb/sv/tb_huffman_merge_cost_unit.sv
// Self-checking testbench of huffman_merge_cost_unit: piece sets, merge cost, leaf order.
// Depends on hmc_pkg and the unit's RTL. A scoreboard class predicts every result.
module tb_huffman_merge_cost_unit;

  import hmc_pkg::*;

  localparam int PIECE_CAP   = 64;
  localparam int LEN_BITS    = 16;
  localparam int HOLD_CYCLES = 300;
  localparam logic [IN_LEN_W-1:0] LEN_MASK = {IN_LEN_W{1'b1}} >> (IN_LEN_W - LEN_BITS);

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [LEAF_W-1:0] leaf;
    logic              last;
  } merge_result_t;

  // Predicts the results of each closed set and checks them in order.
  class merge_cost_scoreboard;
    logic [IN_LEN_W-1:0] open_set[$];
    merge_result_t       due[$];
    int unsigned mismatches, compared, dropped, sets_closed, biggest_set;

    function void note_piece(logic [IN_LEN_W-1:0] len, logic lst);
      if (open_set.size() < PIECE_CAP) open_set = {open_set, len & LEN_MASK};
      else dropped++;
      if (lst) close_set();
    endfunction

    // Sort ascending, then two-queue merge: sorted leaves plus a FIFO of sums.
    function void close_set();
      logic [IN_LEN_W-1:0] leaves[PIECE_CAP];
      logic [IN_LEN_W-1:0] key;
      longint unsigned     sums[$];
      longint unsigned     cost, pair_sum;
      int                  n, i, j, li, qh, p;
      merge_result_t       r;
      n = open_set.size();
      for (i = 0; i < n; i++) leaves[i] = open_set[i];
      for (i = 1; i < n; i++) begin
        key = leaves[i];
        j = i;
        while (j > 0 && leaves[j-1] > key) begin
          leaves[j] = leaves[j-1];
          j--;
        end
        leaves[j] = key;
      end
      cost = 0;
      li = 0;
      qh = 0;
      for (i = 1; i < n; i++) begin
        pair_sum = 0;
        for (p = 0; p < 2; p++) begin
          // merged sum wins a tie with a leaf
          if (li < n && (qh >= sums.size() || leaves[li] < sums[qh])) begin
            pair_sum += leaves[li];
            li++;
          end else begin
            pair_sum += sums[qh];
            qh++;
          end
        end
        sums = {sums, pair_sum};
        cost += pair_sum;
        if (cost > COST_MAX) cost = COST_MAX;
      end
      for (i = 0; i < n; i++) begin
        r.cost = cost[COST_W-1:0];
        r.leaf = leaves[n-1-i];
        r.last = (i == n - 1);
        due = {due, r};
      end
      sets_closed++;
      if (n > biggest_set) biggest_set = n;
      open_set.delete();
    endfunction

    function void check_result(logic [COST_W-1:0] cost, logic [LEAF_W-1:0] leaf,
                               logic lst);
      merge_result_t want, got;
      got = '{cost: cost, leaf: leaf, last: lst};
      if (due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: cost %0d leaf %0d last %0b", cost, leaf, lst);
        return;
      end
      want = due.pop_front();
      compared++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d wrong: expected cost %0d leaf %0d last %0b, got %0d %0d %0b",
                   compared, want.cost, want.leaf, want.last, cost, leaf, lst);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst          = 1'b1;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic [IN_LEN_W-1:0] piece_length = '0;
  logic                last_piece   = 1'b0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic [COST_W-1:0]   total_cost;
  logic [LEAF_W-1:0]   leaf_length;
  logic                last_result;

  merge_cost_scoreboard sb;
  bit          idle_on  = 1'b1;  // random gaps and stalls on both sides
  bit          hold_req = 1'b0;  // ask the receiver for one long hold-off
  int unsigned pieces_sent, holds_done;

  huffman_merge_cost_unit #(
    .MAX_PIECES (PIECE_CAP),
    .LENGTH_BITS(LEN_BITS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .piece_length(piece_length),
    .last_piece  (last_piece),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .total_cost  (total_cost),
    .leaf_length (leaf_length),
    .last_result (last_result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One input transfer; returns in the step right after it was accepted.
  task automatic send_piece(input logic [IN_LEN_W-1:0] len, input logic lst);
    while (idle_on && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    piece_length <= len;
    last_piece   <= lst;
    do @(posedge clk); while (in_stall);
    sb.note_piece(len, lst);
    pieces_sent++;
  endtask

  function automatic logic [IN_LEN_W-1:0] random_length();
    case ($urandom_range(0, 5))
      0:       return IN_LEN_W'($urandom_range(0, 3));  // many equal weights
      1:       return $urandom_range(0, 1) ? {IN_LEN_W{1'b1}} : '0;
      2:       return IN_LEN_W'(1) << $urandom_range(0, IN_LEN_W - 1);
      default: return IN_LEN_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_set(input int unsigned size);
    for (int unsigned i = 0; i < size; i++) send_piece(random_length(), i == size - 1);
  endtask

  // Input goes quiet until every predicted result has come back.
  task automatic wait_drained();
    if (in_valid) in_valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
  endtask

  // Receiver: checks each transfer, stalls at random or for a counted hold-off.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) sb.check_result(total_cost, leaf_length, last_result);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
        holds_done++;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= idle_on && ($urandom_range(99) < 35);
      end
    end
  end

  initial begin
    int unsigned size;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single pieces: zero and full scale, each gives cost 0
    send_piece(16'h0000, 1'b1);
    send_piece(16'hFFFF, 1'b1);
    // extremes mixed
    send_piece(16'hFFFF, 1'b0);
    send_piece(16'h0000, 1'b0);
    send_piece(16'hFFFF, 1'b1);
    // leaf equal to a merged sum
    send_piece(16'd2, 1'b0);
    send_piece(16'd1, 1'b0);
    send_piece(16'd2, 1'b0);
    send_piece(16'd1, 1'b1);
    // alternating bit patterns
    send_piece(16'h5555, 1'b0);
    send_piece(16'hAAAA, 1'b1);
    // all equal
    repeat (4) send_piece(16'd7, 1'b0);
    send_piece(16'd7, 1'b1);
    // rising powers of two, then full scale
    for (int b = 0; b < 7; b++) send_piece(16'(1) << (2 * b + 1), 1'b0);
    send_piece(16'hFFFF, 1'b1);
    wait_drained();

    // long receiver hold-off while the next set queues up behind the first
    hold_req = 1'b1;
    send_set(6);
    send_set(5);
    wait_drained();

    // store exactly full, then overfull with the closing flag on a dropped piece
    send_set(PIECE_CAP);
    wait_drained();
    send_set(PIECE_CAP + 6);
    wait_drained();

    while (pieces_sent < 380) begin
      idle_on = !(pieces_sent >= 220 && pieces_sent < 290);
      case ($urandom_range(0, 9))
        0:       size = $urandom_range(9, 24);
        1:       size = 1;
        default: size = $urandom_range(2, 8);
      endcase
      send_set(size);
      if ($urandom_range(0, 5) == 0) wait_drained();
    end
    idle_on = 1'b1;
    wait_drained();
    repeat (60) @(posedge clk);

    $display("Covered %0d sets from %0d pieces (%0d dropped at capacity, largest set %0d).",
             sb.sets_closed, pieces_sent, sb.dropped, sb.biggest_set);
    $display("Compared %0d results; %0d long receiver hold-off(s) of %0d cycles.",
             sb.compared, holds_done, HOLD_CYCLES);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timeout: %0d results still pending", sb.due.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> filelist.f
rtl/hmc_pkg.sv
rtl/hmc_datapath.sv
rtl/hmc_ctrl.sv
rtl/huffman_merge_cost_unit.sv
tb/sv/tb_huffman_merge_cost_unit.sv
